### src/alignment_statistics_counter_assert.svh
// Assertion macros for the alignment statistics counter.
`ifndef ALIGNMENT_STATISTICS_COUNTER_ASSERT_SVH
`define ALIGNMENT_STATISTICS_COUNTER_ASSERT_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted.
`define ASC_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property, also checked during reset.
`define ASC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASC_ASSERT(lbl, clk, rstn, prop, msg)
`define ASC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

### src/asc_pkg.sv
// Shared constants and types of the alignment statistics counter.
package asc_pkg;

  localparam int COUNT_BITS  = 20;
  localparam int KIND_W      = 2;
  localparam int CODE_W      = 4;
  localparam int PCT_W       = 15;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 2;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_W       = COUNT_BITS + PCT_W;
  localparam int PCT_STEP_W  = $clog2(PCT_W);
  localparam int PCT_SCALE   = 25600;
  localparam int QUEUE_DEPTH = 2;   // power of two, pointers wrap
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [CODE_W-1:0]     GAP_CODE  = 4'd15;

  localparam logic [KIND_W-1:0] KIND_SUB = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DEL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_INS = 2'd2;

  typedef logic [COUNT_BITS-1:0] count_t;

  // Totals of one finished alignment.
  typedef struct packed {
    count_t length;
    count_t ident;
    count_t pos;
    count_t gap_col;
    count_t gap_open;
    logic   sat;
  } asc_snap_t;

  typedef struct packed {
    logic full;
    logic empty;
  } asc_qstat_t;

endpackage

### src/asc_if.sv
// Column and result channel interfaces.
interface asc_in_if import asc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] column_kind;
  logic [CODE_W-1:0] query_code;
  logic [CODE_W-1:0] subject_code;
  logic              op_first;
  logic              column_last;

  modport source (output valid, column_kind, query_code, subject_code, op_first,
                  column_last, input ready);
  modport sink   (input valid, column_kind, query_code, subject_code, op_first,
                  column_last, output ready);
endinterface

interface asc_out_if import asc_pkg::*; ();
  logic             valid;
  logic             ready;
  count_t           length_total;
  count_t           identity_total;
  count_t           positive_total;
  count_t           gap_column_total;
  count_t           gap_open_total;
  logic [PCT_W-1:0] identity_percent_q8;
  logic             count_saturated;

  modport source (output valid, length_total, identity_total, positive_total,
                  gap_column_total, gap_open_total, identity_percent_q8,
                  count_saturated, input ready);
  modport sink   (input valid, length_total, identity_total, positive_total,
                  gap_column_total, gap_open_total, identity_percent_q8,
                  count_saturated, output ready);
endinterface

### src/alignment_statistics_counter.sv
// Top level of the alignment statistics counter.
//
//  channel  dir  handshake     word
//  in_col   in   valid/ready   one alignment column
//  out_res  out  valid/ready   totals and percent identity of one alignment
//  cfg_*    in   write enable  one 64-bit positivity row group
//
// The front takes one column per cycle while in_col.ready is high and updates its counters in that cycle.
// In the back each alignment's result goes through a pop, a multiply by 25600,
// 15 shift-subtract division steps and an output load that waits for a free output.
// A two-entry queue holds finished totals; in_col.ready drops only when it
// is full, which happens when alignments arrive faster than the back drains.
// Reset is synchronous (rst_n low): counters, positivity rows, queue and the
// back sequencer clear at once; there is no clearing pass.
`include "alignment_statistics_counter_assert.svh"

module alignment_statistics_counter import asc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  asc_in_if.sink               in_col,
  asc_out_if.source            out_res,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data
);

  asc_qstat_t q_stat;
  logic       q_push;
  logic       q_pop;
  asc_snap_t  q_in;
  asc_snap_t  q_out;
  logic       res_in_range;

  // column counting; pushes totals on the last column
  asc_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_col      (in_col),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_data      (q_in)
  );

  asc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .stat      (q_stat)
  );

  // division and result register
  asc_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_stat  (q_stat),
    .q_data  (q_out),
    .q_pop   (q_pop),
    .out_res (out_res)
  );

  assign res_in_range = (out_res.identity_total <= out_res.length_total) &&
                        (out_res.identity_percent_q8 <= PCT_W'(PCT_SCALE));

  // a full queue must stall the column input
  `ASC_ASSERT(a_full_stalls, clk, rst_n, q_stat.full |-> !in_col.ready, "queue full but input ready")
  // back never pops an empty queue
  `ASC_ASSERT(a_pop_nonempty, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty queue")
  // identities never exceed length, percent never exceeds 100
  `ASC_ASSERT(a_ident_le_len, clk, rst_n, out_res.valid |-> res_in_range, "result out of range")
  // a result always covers at least one column
  `ASC_ASSERT(a_len_nonzero, clk, rst_n, out_res.valid |-> (out_res.length_total != '0), "zero length result")

endmodule

### src/asc_queue.sv
// Short queue of finished alignment totals between front and back.
module asc_queue import asc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  asc_snap_t  push_data,
  input  logic       pop,
  output asc_snap_t  pop_data,
  output asc_qstat_t stat
);

  asc_snap_t         mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (cnt_r == (QPTR_W+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### src/asc_front.sv
// Column front end: positivity lookup and saturating alignment counters.
module asc_front import asc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  asc_in_if.sink               in_col,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wr_data,
  input  asc_qstat_t           q_stat,
  output logic                 q_push,
  output asc_snap_t            q_data
);

  logic [CFG_W-1:0]  rows_r [NUM_ROWS];
  count_t            len_r, ident_r, pos_r, gcol_r, gopen_r;
  logic              sat_r;

  logic              accept;
  logic [CODE_W-1:0] q_sel;
  logic [CODE_W-1:0] s_sel;
  logic [CFG_W-1:0]  row;
  logic              pos_bit;
  logic              is_sub, is_gap;
  logic [COUNT_BITS:0] b_len, b_ident, b_pos, b_gcol, b_gopen;
  asc_snap_t         nxt;

  // Saturating increment; top bit flags that the ceiling is reached.
  function automatic logic [COUNT_BITS:0] bump(input count_t acc, input logic en);
    count_t v;
    v = acc;
    if (en && (acc != COUNT_MAX)) begin
      v = acc + 1'b1;
    end
    return {en && (v == COUNT_MAX), v};
  endfunction

  assign in_col.ready = !q_stat.full;
  assign accept       = in_col.valid && in_col.ready;

  always_comb begin
    is_sub = (in_col.column_kind == KIND_SUB);
    is_gap = (in_col.column_kind == KIND_DEL) || (in_col.column_kind == KIND_INS);
    // missing side of a gap column looks up as the gap code
    q_sel  = (in_col.column_kind == KIND_DEL) ? GAP_CODE : in_col.query_code;
    s_sel  = (in_col.column_kind == KIND_INS) ? GAP_CODE : in_col.subject_code;
    row    = rows_r[q_sel[CODE_W-1:2]];
    pos_bit = row[{q_sel[1:0], s_sel}];

    b_len   = bump(len_r, 1'b1);
    b_ident = bump(ident_r, is_sub && (in_col.query_code == in_col.subject_code));
    b_pos   = bump(pos_r, (is_sub || is_gap) && pos_bit);
    b_gcol  = bump(gcol_r, is_gap);
    b_gopen = bump(gopen_r, is_gap && in_col.op_first);

    nxt.length   = b_len[COUNT_BITS-1:0];
    nxt.ident    = b_ident[COUNT_BITS-1:0];
    nxt.pos      = b_pos[COUNT_BITS-1:0];
    nxt.gap_col  = b_gcol[COUNT_BITS-1:0];
    nxt.gap_open = b_gopen[COUNT_BITS-1:0];
    nxt.sat      = sat_r || b_len[COUNT_BITS] || b_ident[COUNT_BITS] ||
                   b_pos[COUNT_BITS] || b_gcol[COUNT_BITS] || b_gopen[COUNT_BITS];
  end

  assign q_push = accept && in_col.column_last;
  assign q_data = nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        rows_r[i] <= '0;
      end
      len_r   <= '0;
      ident_r <= '0;
      pos_r   <= '0;
      gcol_r  <= '0;
      gopen_r <= '0;
      sat_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        rows_r[cfg_index] <= cfg_wr_data;
      end
      if (accept) begin
        if (in_col.column_last) begin
          len_r   <= '0;
          ident_r <= '0;
          pos_r   <= '0;
          gcol_r  <= '0;
          gopen_r <= '0;
          sat_r   <= 1'b0;
        end else begin
          len_r   <= nxt.length;
          ident_r <= nxt.ident;
          pos_r   <= nxt.pos;
          gcol_r  <= nxt.gap_col;
          gopen_r <= nxt.gap_open;
          sat_r   <= nxt.sat;
        end
      end
    end
  end

endmodule

### src/asc_back.sv
// Result back end: percent identity by shift-subtract division, output register.
module asc_back import asc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  asc_qstat_t q_stat,
  input  asc_snap_t  q_data,
  output logic       q_pop,
  asc_out_if.source  out_res
);

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_DIV, S_OUT} state_t;

  state_t                state_r;
  asc_snap_t             snap_r;
  logic [NUM_W-1:0]      rem_r;
  logic [NUM_W-1:0]      div_r;
  logic [PCT_W-1:0]      quo_r;
  logic [PCT_STEP_W-1:0] step_r;
  logic                  out_valid_r;
  asc_snap_t             res_r;
  logic [PCT_W-1:0]      pct_r;
  logic                  ge;
  logic                  out_free;

  assign q_pop    = (state_r == S_IDLE) && !q_stat.empty;
  assign ge       = (rem_r >= div_r);
  assign out_free = !out_valid_r || out_res.ready;

  assign out_res.valid               = out_valid_r;
  assign out_res.length_total        = res_r.length;
  assign out_res.identity_total      = res_r.ident;
  assign out_res.positive_total      = res_r.pos;
  assign out_res.gap_column_total    = res_r.gap_col;
  assign out_res.gap_open_total      = res_r.gap_open;
  assign out_res.count_saturated     = res_r.sat;
  assign out_res.identity_percent_q8 = pct_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if ((state_r == S_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (q_pop) begin
            snap_r  <= q_data;
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          rem_r   <= NUM_W'(snap_r.ident) * NUM_W'(PCT_SCALE);
          div_r   <= NUM_W'({snap_r.length, {(PCT_W-1){1'b0}}});
          quo_r   <= '0;
          step_r  <= '0;
          state_r <= S_DIV;
        end
        S_DIV: begin
          if (ge) begin
            rem_r <= rem_r - div_r;
          end
          quo_r  <= {quo_r[PCT_W-2:0], ge};
          div_r  <= div_r >> 1;
          step_r <= step_r + 1'b1;
          if (step_r == PCT_STEP_W'(PCT_W-1)) begin
            state_r <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            res_r   <= snap_r;
            pct_r   <= (snap_r.length == '0) ? '0 : quo_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench of the alignment statistics counter.
import asc_pkg::*;

// Kind code the block has no operation for; it counts as a plain column.
localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

// Positivity row group registers, in index order.
typedef enum logic [CFG_IDX_W-1:0] {
  ROWS_0_3, ROWS_4_7, ROWS_8_11, ROWS_12_15
} pos_row_e;

// Fill patterns for a positivity row group.
typedef enum int {PAT_ZERO, PAT_ONES, PAT_ODD_BITS, PAT_EVEN_BITS, PAT_RANDOM} row_pattern_e;

typedef struct packed {
  logic [KIND_W-1:0] kind;
  logic [CODE_W-1:0] query;
  logic [CODE_W-1:0] subject;
  logic              first;
  logic              last;
} column_t;

typedef struct packed {
  count_t           length;
  count_t           ident;
  count_t           pos;
  count_t           gap_col;
  count_t           gap_open;
  logic [PCT_W-1:0] pct;
  logic             sat;
} totals_t;

// Running totals of the open alignment and the totals still owed by the block.
class align_totals_board;
  bit [CFG_W-1:0] rows [NUM_ROWS];
  count_t         length = '0, ident = '0, pos = '0, gap_col = '0, gap_open = '0;
  bit             sat;
  totals_t        owed_totals [$];
  int             errors;

  function bit positive(logic [CODE_W-1:0] q, logic [CODE_W-1:0] s);
    bit [CFG_W-1:0] row;
    row = rows[q[3:2]];
    return row[{q[1:0], s}];
  endfunction

  function count_t bump(count_t acc);
    if (acc < COUNT_MAX) acc = acc + 1'b1;
    if (acc == COUNT_MAX) sat = 1'b1;
    return acc;
  endfunction

  function void note_column(column_t c);
    totals_t        t;
    bit [63:0]      scaled;
    bit             gap_pos;
    length = bump(length);
    case (c.kind)
      KIND_SUB: begin
        if (c.query == c.subject) ident = bump(ident);
        if (positive(c.query, c.subject)) pos = bump(pos);
      end
      KIND_DEL, KIND_INS: begin
        // the missing side looks up as the gap code
        gap_pos = (c.kind == KIND_DEL) ? positive(GAP_CODE, c.subject)
                                       : positive(c.query, GAP_CODE);
        if (gap_pos) pos = bump(pos);
        gap_col = bump(gap_col);
        if (c.first) gap_open = bump(gap_open);
      end
      default: ;
    endcase
    if (c.last) begin
      scaled     = (length != '0) ? (64'(PCT_SCALE) * 64'(ident)) / 64'(length) : 64'd0;
      t.length   = length;
      t.ident    = ident;
      t.pos      = pos;
      t.gap_col  = gap_col;
      t.gap_open = gap_open;
      t.pct      = scaled[PCT_W-1:0];
      t.sat      = sat;
      owed_totals.push_back(t);
      length = '0; ident = '0; pos = '0; gap_col = '0; gap_open = '0; sat = 1'b0;
    end
  endfunction

  function void compare(string field, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      errors++;
    end
  endfunction

  function void check_result(totals_t got);
    totals_t want;
    if (owed_totals.size() == 0) begin
      $display("%0t: result word with no alignment owed, got length %0d",
               $time, got.length);
      errors++;
    end else begin
      want = owed_totals.pop_front();
      compare("length_total",        32'(want.length),   32'(got.length));
      compare("identity_total",      32'(want.ident),    32'(got.ident));
      compare("positive_total",      32'(want.pos),      32'(got.pos));
      compare("gap_column_total",    32'(want.gap_col),  32'(got.gap_col));
      compare("gap_open_total",      32'(want.gap_open), 32'(got.gap_open));
      compare("identity_percent_q8", 32'(want.pct),      32'(got.pct));
      compare("count_saturated",     32'(want.sat),      32'(got.sat));
    end
  endfunction

  function int pending();
    return owed_totals.size();
  endfunction
endclass

module testbench;
  localparam int DRAIN_WAIT   = 24;    // lets the back stage finish its division
  localparam int END_WAIT     = 40;
  localparam int STALL_LIMIT  = 2000;  // cycles with no word moving on in_col or out_res
  localparam int PHASE_ITEMS  = 411;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_wr_en;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wr_data;

  asc_in_if  in_col ();
  asc_out_if out_res ();

  alignment_statistics_counter dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_col      (in_col),
    .out_res     (out_res),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_index   (cfg_index),
    .cfg_wr_data (cfg_wr_data)
  );

  align_totals_board board = new();

  int tx_idle_pct;     // chance in percent that the sender skips a cycle
  int rx_idle_pct;     // chance in percent that the receiver holds off
  int columns_sent;

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Monitor: both channels sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_col.valid && in_col.ready)
        board.note_column({in_col.column_kind, in_col.query_code, in_col.subject_code,
                           in_col.op_first, in_col.column_last});
      if (out_res.valid && out_res.ready)
        board.check_result({out_res.length_total, out_res.identity_total,
                            out_res.positive_total, out_res.gap_column_total,
                            out_res.gap_open_total, out_res.identity_percent_q8,
                            out_res.count_saturated});
    end
  end

  // Receiver: ready redrawn at every falling edge.
  initial begin
    out_res.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_res.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: ends the run once nothing has moved for too long.
  initial begin : watchdog
    int stall;
    stall = 0;
    while (stall < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_col.valid && in_col.ready) || (out_res.valid && out_res.ready))
        stall = 0;
      else
        stall++;
    end
    $display("%0t: no traffic for %0d cycles", $time, STALL_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic column_t col(logic [KIND_W-1:0] kind, logic [CODE_W-1:0] q,
                                  logic [CODE_W-1:0] s, logic first, logic last);
    return {kind, q, s, first, last};
  endfunction

  function automatic bit [CFG_W-1:0] row_pattern(row_pattern_e pat);
    case (pat)
      PAT_ZERO:      return '0;
      PAT_ONES:      return '1;
      PAT_ODD_BITS:  return {32{2'b10}};
      PAT_EVEN_BITS: return {32{2'b01}};
      default:       return {$urandom, $urandom};
    endcase
  endfunction

  // Sends one column word; called and returns at a falling edge.
  // valid stays high across back-to-back words.
  task automatic send_column(column_t c);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_col.valid <= 1'b0;
      @(negedge clk);
    end
    in_col.valid        <= 1'b1;
    in_col.column_kind  <= c.kind;
    in_col.query_code   <= c.query;
    in_col.subject_code <= c.subject;
    in_col.op_first     <= c.first;
    in_col.column_last  <= c.last;
    @(posedge clk);
    while (!in_col.ready) @(posedge clk);
    @(negedge clk);
    columns_sent++;
  endtask

  // Sender holds off until every owed result is back, then lets the back settle.
  task automatic drain();
    in_col.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  // Write enable stays high across the row writes; dropped by set_table.
  task automatic write_row(pos_row_e idx, bit [CFG_W-1:0] value);
    cfg_wr_en   <= 1'b1;
    cfg_index   <= idx;
    cfg_wr_data <= value;
    board.rows[idx] = value;
    @(negedge clk);
  endtask

  task automatic set_table(bit [CFG_W-1:0] r0, bit [CFG_W-1:0] r1,
                           bit [CFG_W-1:0] r2, bit [CFG_W-1:0] r3);
    write_row(ROWS_0_3, r0);
    write_row(ROWS_4_7, r1);
    write_row(ROWS_8_11, r2);
    write_row(ROWS_12_15, r3);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic set_mixed_table();
    set_table(row_pattern(row_pattern_e'($urandom_range(4))),
              row_pattern(row_pattern_e'($urandom_range(4))),
              row_pattern(row_pattern_e'($urandom_range(4))),
              row_pattern(row_pattern_e'($urandom_range(4))));
  endtask

  // One alignment built from edit operations, each a run of one kind whose
  // first column carries op_first. About one in ten is noise: kinds drawn per
  // column, the spare kind included, and op_first drawn at random.
  task automatic send_alignment();
    int               ops, run;
    bit               noisy;
    logic [KIND_W-1:0] kind;
    column_t          c;
    noisy = ($urandom_range(9) == 0);
    ops   = ($urandom_range(3) == 0) ? $urandom_range(10, 1) : $urandom_range(3, 1);
    for (int op = 0; op < ops; op++) begin
      kind = noisy ? KIND_W'($urandom_range(3)) : KIND_W'($urandom_range(2));
      run  = ($urandom_range(4) == 0) ? $urandom_range(16, 1) : $urandom_range(3, 1);
      for (int j = 0; j < run; j++) begin
        c.kind    = noisy ? KIND_W'($urandom_range(3)) : kind;
        c.query   = CODE_W'($urandom_range(15));
        // at least a third of the pairs match, so identities stay frequent
        c.subject = ($urandom_range(2) == 0) ? c.query : CODE_W'($urandom_range(15));
        c.first   = noisy ? 1'($urandom_range(1)) : (j == 0);
        c.last    = (op == ops - 1) && (j == run - 1);
        send_column(c);
      end
    end
  endtask

  // Random alignments under one idling mix; the table is rewritten every
  // hundred or so columns while the block is idle.
  task automatic random_phase(int tx_pct, int rx_pct, row_pattern_e first_pat);
    int stop_at, next_table_at;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at     = columns_sent + PHASE_ITEMS;
    drain();
    set_table(row_pattern(first_pat), row_pattern(first_pat),
              row_pattern(first_pat), row_pattern(first_pat));
    next_table_at = columns_sent + $urandom_range(160, 80);
    while (columns_sent < stop_at) begin
      if (columns_sent >= next_table_at) begin
        drain();
        set_mixed_table();
        next_table_at = columns_sent + $urandom_range(160, 80);
      end
      send_alignment();
    end
  endtask

  initial begin : stimulus
    rst_n               = 1'b0;
    cfg_wr_en           = 1'b0;
    cfg_index           = '0;
    cfg_wr_data         = '0;
    in_col.valid        = 1'b0;
    in_col.column_kind  = '0;
    in_col.query_code   = '0;
    in_col.subject_code = '0;
    in_col.op_first     = 1'b0;
    in_col.column_last  = 1'b0;
    tx_idle_pct         = 29;
    rx_idle_pct         = 86;
    columns_sent        = 0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under a random table.
    set_table({$urandom, $urandom}, {$urandom, $urandom},
              {$urandom, $urandom}, {$urandom, $urandom});
    // single-column alignments: each kind, code extremes, spare kind gives 0%
    send_column(col(KIND_SUB,   4'd0,  4'd0,  1'b1, 1'b1));
    send_column(col(KIND_SUB,   4'd15, 4'd15, 1'b1, 1'b1));
    send_column(col(KIND_SUB,   4'd0,  4'd15, 1'b1, 1'b1));
    send_column(col(KIND_DEL,   4'd15, 4'd0,  1'b1, 1'b1));
    send_column(col(KIND_INS,   4'd0,  4'd15, 1'b1, 1'b1));
    send_column(col(KIND_SPARE, 4'd7,  4'd7,  1'b1, 1'b1));
    // mixed alignment: gap runs open once each, spare kind in the middle
    send_column(col(KIND_SUB,   4'd3,  4'd3,  1'b1, 1'b0));
    send_column(col(KIND_DEL,   4'd0,  4'd5,  1'b1, 1'b0));
    send_column(col(KIND_DEL,   4'd0,  4'd9,  1'b0, 1'b0));
    send_column(col(KIND_INS,   4'd12, 4'd0,  1'b1, 1'b0));
    send_column(col(KIND_INS,   4'd6,  4'd0,  1'b0, 1'b0));
    send_column(col(KIND_SPARE, 4'd1,  4'd2,  1'b1, 1'b0));
    send_column(col(KIND_SUB,   4'd8,  4'd8,  1'b1, 1'b0));
    send_column(col(KIND_SUB,   4'd4,  4'd11, 1'b0, 1'b1));
    // gap columns without op_first are not opens; open and last on one column
    send_column(col(KIND_DEL,   4'd2,  4'd14, 1'b0, 1'b0));
    send_column(col(KIND_INS,   4'd10, 4'd1,  1'b0, 1'b0));
    send_column(col(KIND_DEL,   4'd5,  4'd15, 1'b1, 1'b1));

    // Random part: slow receiver, then slow sender, then full rate.
    random_phase(29, 86, PAT_ZERO);
    random_phase(86, 29, PAT_ONES);
    random_phase(0,  0,  PAT_RANDOM);

    in_col.valid <= 1'b0;
    while (board.pending() != 0) @(negedge clk);
    repeat (END_WAIT) @(negedge clk);
    if (board.errors == 0 && board.pending() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end
endmodule

### alignment_statistics_counter.f
+incdir+src
src/asc_pkg.sv
src/asc_if.sv
src/asc_queue.sv
src/asc_front.sv
src/asc_back.sv
src/alignment_statistics_counter.sv
tb/testbench.sv
